/* hw/rtl/iso_week_number_macros.svh */
// Assertion macros for the ISO week number block.
// Used by iso_week_number.sv; needs no other file.
`ifndef ISO_WEEK_NUMBER_MACROS_SVH
`define ISO_WEEK_NUMBER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define IWN_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("iso_week_number: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define IWN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("iso_week_number: next-cycle check failed");

`endif

/* hw/rtl/iwn_pkg.sv */
// Shared types, constants and small functions for the ISO week number block.
// No dependencies; imported by iwn_year_calc, iwn_week_calc and iso_week_number.
`default_nettype none

package iwn_pkg;

  localparam int NumStages = 6;

  // year + 399: the prior year, shifted by one 400-year cycle
  localparam logic [14:0] YearOffset = 15'd399;
  // (x >> 2) * 1311 >> 15 == x / 100 for x below 18724
  localparam logic [10:0] Div25Mul   = 11'd1311;
  // x * 293 >> 11 == x / 7 for x below 683
  localparam logic [8:0]  Div7Mul    = 9'd293;
  localparam logic [6:0]  Hundred    = 7'd100;

  localparam logic [5:0]  WeeksLong  = 6'd53;
  localparam logic [5:0]  WeeksShort = 6'd52;
  localparam logic [5:0]  WeekFirst  = 6'd1;

  // weekday codes, Monday = 0
  localparam logic [2:0]  WdWed = 3'd2;
  localparam logic [2:0]  WdThu = 3'd3;
  localparam logic [2:0]  WdFri = 3'd4;
  localparam logic [2:0]  WdSat = 3'd5;

  typedef struct packed {
    logic [14:0] sum;         // day count of the prior years, not yet reduced mod 7
    logic        leap_prior;
    logic        leap_cur;
    logic [8:0]  base;        // days of the months before, plus day, no leap day
    logic        late;        // month past February
  } year_info_t;

  // mod 7 by folding 3-bit chunks (8 == 1 mod 7)
  function automatic logic [2:0] mod7(input logic [15:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
       + 6'(v[15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

  // days before the first of the month; month 0 acts as January, above 12 as December
  function automatic logic [8:0] month_cum(input logic [3:0] m);
    logic [8:0] c;
    case (m)
      4'd0, 4'd1: c = 9'd0;
      4'd2:       c = 9'd31;
      4'd3:       c = 9'd59;
      4'd4:       c = 9'd90;
      4'd5:       c = 9'd120;
      4'd6:       c = 9'd151;
      4'd7:       c = 9'd181;
      4'd8:       c = 9'd212;
      4'd9:       c = 9'd243;
      4'd10:      c = 9'd273;
      4'd11:      c = 9'd304;
      default:    c = 9'd334;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/iwn_year_calc.sv */
// Stages 0..2: year split into century and rest, leap flags, month offset.
// Depends on iwn_pkg.
`default_nettype none

module iwn_year_calc (
  input  wire logic              clk_i,
  input  wire logic [2:0]        en_i,
  input  wire logic [13:0]       year_i,
  input  wire logic [3:0]        month_i,
  input  wire logic [4:0]        day_i,
  output iwn_pkg::year_info_t    info_o
);
  import iwn_pkg::*;

  logic [14:0] r0_q, r1_q;
  logic [8:0]  base0_q, base1_q;
  logic        late0_q, late1_q;
  logic [22:0] prod1_q;
  year_info_t  info_d, info_q;

  logic [7:0]  cent;
  logic [14:0] rem_full;
  logic [6:0]  rem;

  // stage 0
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r0_q    <= 15'(year_i) + YearOffset;
      base0_q <= month_cum(month_i) + 9'(day_i);
      late0_q <= (month_i > 4'd2);
    end
  end

  // stage 1: reciprocal multiply for /100
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod1_q <= 23'(r0_q[14:2]) * 23'(Div25Mul);
      r1_q    <= r0_q;
      base1_q <= base0_q;
      late1_q <= late0_q;
    end
  end

  // stage 2
  always_comb begin
    cent     = prod1_q[22:15];
    rem_full = r1_q - 15'(cent) * 15'(Hundred);
    rem      = rem_full[6:0];
    info_d.leap_prior = ((r1_q[1:0] == 2'd0) && (rem != 7'd0)) ||
                        ((rem == 7'd0) && (cent[1:0] == 2'd0));
    // current year is r + 1
    info_d.leap_cur   = ((r1_q[1:0] == 2'd3) && (rem != 7'd99)) ||
                        ((rem == 7'd99) && (cent[1:0] == 2'd3));
    info_d.sum  = r1_q + 15'(r1_q[14:2]) - 15'(cent) + 15'(cent[7:2]);
    info_d.base = base1_q;
    info_d.late = late1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      info_q <= info_d;
    end
  end

  assign info_o = info_q;

endmodule

`default_nettype wire

/* hw/rtl/iwn_week_calc.sv */
// Stages 3..5: Jan 1 weekday, ordinal, weekday, raw week and year-edge fixup.
// Depends on iwn_pkg.
`default_nettype none

module iwn_week_calc (
  input  wire logic              clk_i,
  input  wire logic [2:0]        en_i,
  input  wire iwn_pkg::year_info_t info_i,
  output logic [5:0]             week_o
);
  import iwn_pkg::*;

  logic [2:0]  jan1_q;
  logic [8:0]  ord_q;
  logic        leap_prior3_q, leap_cur3_q;

  logic [2:0]  wd;
  logic [8:0]  x_q;
  logic        long_cur_q, long_prior_q;

  logic [17:0] prod;
  logic [5:0]  raw;
  logic [5:0]  week_d, week_q;

  // stage 3
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      jan1_q        <= mod7(16'(info_i.sum));
      ord_q         <= info_i.base + 9'(info_i.late & info_i.leap_cur);
      leap_prior3_q <= info_i.leap_prior;
      leap_cur3_q   <= info_i.leap_cur;
    end
  end

  // stage 4: weekday of the date is Jan 1 weekday plus ordinal - 1
  assign wd = mod7(16'(jan1_q) + 16'(ord_q) + 16'd6);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      x_q          <= ord_q + 9'd9 - 9'(wd);
      long_cur_q   <= (jan1_q == WdThu) || ((jan1_q == WdWed) && leap_cur3_q);
      // prior Jan 1 sits 1 (or 2 if prior was leap) days before this one
      long_prior_q <= (jan1_q == WdFri) || ((jan1_q == WdSat) && leap_prior3_q);
    end
  end

  // stage 5
  always_comb begin
    prod = 18'(x_q) * 18'(Div7Mul);
    raw  = prod[16:11];
    if (raw == 6'd0) begin
      week_d = long_prior_q ? WeeksLong : WeeksShort;
    end else if ((raw == WeeksLong) && !long_cur_q) begin
      week_d = WeekFirst;
    end else begin
      week_d = raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      week_q <= week_d;
    end
  end

  assign week_o = week_q;

endmodule

`default_nettype wire

/* hw/rtl/iso_week_number.sv */
// ISO 8601 week number of a Gregorian date, six-stage pipeline.
// Throughput: one word per cycle while the output is not stalled; accepted words pass
// through stages 0..5 in order. Each stage advances when empty or when the next moves.
// A stalled output stage holds its word; upstream stages keep filling bubbles.
// Reset (rst_ni low, async) clears all stage valid bits; data regs are not reset.
`default_nettype none

module iso_week_number (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [13:0] year, [17:14] month, [22:18] day, [23] 0
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata    // [5:0] week, [7:6] 0
);
  import iwn_pkg::*;

  `include "iso_week_number_macros.svh"

  logic [NumStages-1:0] valid_d, valid_q;
  logic [NumStages-1:0] stage_en;
  year_info_t           info;
  logic [5:0]           week;

  // Stage k loads when it is empty or its word moves on this cycle.
  always_comb begin
    stage_en[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (stage_en[0]) begin
      valid_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (stage_en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Year decomposition: stages 0..2
  iwn_year_calc u_year (
    .clk_i   (clk_i),
    .en_i    (stage_en[2:0]),
    .year_i  (s_axis_tdata[13:0]),
    .month_i (s_axis_tdata[17:14]),
    .day_i   (s_axis_tdata[22:18]),
    .info_o  (info)
  );

  // Weekday and week: stages 3..5
  iwn_week_calc u_week (
    .clk_i  (clk_i),
    .en_i   (stage_en[5:3]),
    .info_i (info),
    .week_o (week)
  );

  assign s_axis_tready = stage_en[0];
  assign m_axis_tvalid = valid_q[NumStages-1];
  assign m_axis_tdata  = {2'b00, week};

  // Any word on the output is a legal week number.
  `IWN_ASSERT_NOW(a_week_range, clk_i, rst_ni, m_axis_tvalid,
                  (week != 6'd0) && (week <= WeeksLong))
  // An accepted word lands in stage 0.
  `IWN_ASSERT_NEXT(a_accept_lands, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                   valid_q[0])
  // A held mid-pipe word is not dropped.
  `IWN_ASSERT_NEXT(a_hold_mid, clk_i, rst_ni, valid_q[3] && !stage_en[3], valid_q[3])

endmodule

`default_nettype wire
